// ----- hw/rtl/lpq_pkg.sv -----
`default_nettype none
package lpq_pkg;
   localparam int Capacity = 64;
   localparam int IdxW = $clog2(Capacity + 1);
   localparam int AddrW = $clog2(Capacity);
   localparam logic [IdxW-1:0] NullIdx = IdxW'(Capacity);

   typedef enum logic [1:0] {
      FUNC_PUSH = 2'd0,
      FUNC_TOP  = 2'd1,
      FUNC_POP  = 2'd2,
      FUNC_NOP  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RSVD  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      REL_LE = 2'd0,
      REL_LT = 2'd1,
      REL_GE = 2'd2,
      REL_GT = 2'd3
   } rel_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] elem;
      logic [31:0] prio;
   } req_type;

   typedef struct packed {
      logic [31:0]     elem;
      logic [31:0]     prio;
      logic [1:0]      status;
      logic [IdxW-1:0] count;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic init_step;   // write one free-chain link during the reset sweep
      logic capture;     // latch the request and set up a memory read
      logic link_tail;   // point the current tail at the node being pushed
      logic push_write;  // commit a push
      logic read_best;   // issue read of the best node
      logic unlink_head; // pop of the head node
      logic walk_start;  // start the predecessor walk at the head
      logic walk_step;   // advance the walk
      logic unlink_mid;  // splice the predecessor past the best node
      logic free_best;   // return best node to free chain
      logic scan_start;
      logic scan_step;
      logic scan_done;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic init_done;
      logic is_empty;
      logic is_full;
      logic best_is_head;
      logic walk_hit;    // link of current walk node equals the best node
      logic walk_end;    // current walk node is null or the step count has reached the capacity
      logic scan_end;
   } sts_type;

   function automatic logic rel_holds(input logic [1:0] mode,
                                      input logic signed [31:0] a,
                                      input logic signed [31:0] b);
      logic r;
      unique case (rel_type'(mode))
         REL_LE: r = (a <= b);
         REL_LT: r = (a < b);
         REL_GE: r = (a >= b);
         REL_GT: r = (a > b);
         default: r = 1'b0;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/lpq_if.sv -----
`default_nettype none
interface lpq_req_if;
   logic                valid;
   logic                ready;
   logic [1:0]          func;
   logic signed [31:0]  elem_in;
   logic signed [31:0]  prio_in;
   modport source (output valid, func, elem_in, prio_in, input ready);
   modport sink (input valid, func, elem_in, prio_in, output ready);
endinterface

interface lpq_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [31:0]               elem_out;
   logic signed [31:0]               prio_out;
   logic [1:0]                       status;
   logic [lpq_pkg::IdxW-1:0]         count_out;
   modport source (output valid, elem_out, prio_out, status, count_out, input ready);
   modport sink (input valid, elem_out, prio_out, status, count_out, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/linked_priority_queue.sv -----
`default_nettype none
// Priority queue of up to 64 entries held as an unsorted linked list in node
// memories, with a cached best entry. One transaction at a time: a top fetches the best
// node and responds, and a push also links the tail and writes the new node; a pop whose
// best node is not the head walks the list to find its predecessor, and every pop rescans all
// entries, each step waiting for the registered read through the single node memory
// read port. A stalled receiver holds the response until it is taken. After
// reset a sweep builds the free chain, during which no request is accepted;
// csr_write_enable writes relation_mode, which should change only between transactions.
module linked_priority_queue (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_write_enable,
   input  wire logic [1:0] csr_write_data,
   lpq_req_if.sink         req,
   lpq_rsp_if.source       rsp
);
   logic [1:0]       mode_ff;
   lpq_pkg::cmd_type cmd;
   lpq_pkg::sts_type sts;
   lpq_pkg::req_type req_data;
   lpq_pkg::rsp_type rsp_data;

   always_ff @(posedge clock) begin
      if (reset) mode_ff <= '0;
      else if (csr_write_enable) mode_ff <= csr_write_data;
   end

   assign req_data.func = req.func;
   assign req_data.elem = req.elem_in;
   assign req_data.prio = req.prio_in;

   lpq_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready), .req_func(req.func),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .sts, .cmd
   );

   lpq_datapath u_dp (
      .clock, .reset, .mode(mode_ff), .req(req_data), .cmd, .sts, .rsp(rsp_data)
   );

   assign rsp.elem_out  = rsp_data.elem;
   assign rsp.prio_out  = rsp_data.prio;
   assign rsp.status    = rsp_data.status;
   assign rsp.count_out = rsp_data.count;
endmodule
`default_nettype wire

// ----- hw/rtl/lpq_datapath.sv -----
`default_nettype none
module lpq_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [1:0]          mode,
   input  wire lpq_pkg::req_type    req,
   input  wire lpq_pkg::cmd_type    cmd,
   output      lpq_pkg::sts_type    sts,
   output      lpq_pkg::rsp_type    rsp
);
   localparam int IW = lpq_pkg::IdxW;
   localparam int AW = lpq_pkg::AddrW;

   // Node memories: one write and one registered read per cycle each.
   logic [31:0]   elem_mem [lpq_pkg::Capacity];
   logic [31:0]   prio_mem [lpq_pkg::Capacity];
   logic [IW-1:0] link_mem [lpq_pkg::Capacity];

   logic [31:0]   elem_rd_ff, prio_rd_ff;
   logic [IW-1:0] link_rd_ff;

   logic [IW-1:0] head_ff, head_in, tail_ff, tail_in, free_ff, free_in;
   logic [IW-1:0] best_ff, best_in, count_ff, count_in;
   logic [IW-1:0] init_ff, init_in;
   logic [IW-1:0] cur_ff, cur_in;          // walk / scan pointer
   logic [IW-1:0] scan_best_ff, scan_best_in;
   logic [31:0]   scan_prio_ff, scan_prio_in;
   logic [IW-1:0] steps_ff, steps_in;
   lpq_pkg::req_type req_ff;
   lpq_pkg::rsp_type rsp_ff, rsp_in;
   logic [31:0]   best_elem_ff, best_prio_ff;

   // Link of the best node and flags that a pop or a push succeeded, kept for the response.
   logic [IW-1:0] best_link_ff;
   logic          popped_ff;
   logic          pushed_ff;
   logic          best_fetch_ff;

   logic          link_we, data_we;
   logic [AW-1:0] link_wa, data_wa, rd_a;
   logic [IW-1:0] link_wd;
   logic          cur_valid;

   assign cur_valid = (cur_ff < lpq_pkg::NullIdx);

   always_comb begin
      head_in = head_ff; tail_in = tail_ff; free_in = free_ff;
      best_in = best_ff; count_in = count_ff; init_in = init_ff;
      cur_in = cur_ff; scan_best_in = scan_best_ff; scan_prio_in = scan_prio_ff;
      steps_in = steps_ff; rsp_in = rsp_ff;
      link_we = 1'b0; link_wa = '0; link_wd = '0;
      data_we = 1'b0; data_wa = free_ff[AW-1:0];
      rd_a = cur_ff[AW-1:0];
      if (cmd.init_step) begin
         link_we = 1'b1; link_wa = init_ff[AW-1:0]; link_wd = init_ff + IW'(1);
         init_in = init_ff + IW'(1);
      end
      if (cmd.capture) begin
         // The pointer rests on the free head so that its link stays in the read register.
         rd_a = free_ff[AW-1:0];
         cur_in = free_ff;
      end
      if (cmd.read_best) rd_a = best_ff[AW-1:0];
      if (cmd.link_tail && count_ff != '0) begin
         link_we = 1'b1; link_wa = tail_ff[AW-1:0]; link_wd = free_ff;
      end
      if (cmd.push_write) begin
         // link_rd_ff holds the link of the free head.
         data_we = 1'b1;
         free_in = link_rd_ff;
         link_we = 1'b1; link_wa = free_ff[AW-1:0]; link_wd = lpq_pkg::NullIdx;
         if (count_ff == '0) begin
            head_in = free_ff; best_in = free_ff;
         end else begin
            if (!lpq_pkg::rel_holds(mode, best_prio_ff, req_ff.prio)) best_in = free_ff;
         end
         tail_in = free_ff;
         count_in = count_ff + IW'(1);
      end
      if (cmd.unlink_head) begin
         head_in = best_link_ff;
         if (best_ff == tail_ff) tail_in = lpq_pkg::NullIdx;
      end
      if (cmd.walk_start) begin
         cur_in = head_ff; rd_a = head_ff[AW-1:0]; steps_in = '0;
      end
      if (cmd.walk_step) begin
         cur_in = link_rd_ff; rd_a = link_rd_ff[AW-1:0]; steps_in = steps_ff + IW'(1);
      end
      if (cmd.unlink_mid) begin
         link_we = 1'b1; link_wa = cur_ff[AW-1:0]; link_wd = best_link_ff;
         if (best_ff == tail_ff) tail_in = cur_ff;
      end
      if (cmd.free_best) begin
         link_we = 1'b1; link_wa = best_ff[AW-1:0]; link_wd = free_ff;
         free_in = best_ff;
         count_in = count_ff - IW'(1);
         if (count_ff == IW'(1)) begin
            head_in = lpq_pkg::NullIdx; tail_in = lpq_pkg::NullIdx;
         end
      end
      if (cmd.scan_start) begin
         cur_in = head_ff; rd_a = head_ff[AW-1:0];
         scan_best_in = lpq_pkg::NullIdx; steps_in = '0;
      end
      if (cmd.scan_step) begin
         // Read data belongs to cur_ff.
         if (scan_best_ff == lpq_pkg::NullIdx ||
             lpq_pkg::rel_holds(mode, prio_rd_ff, scan_prio_ff)) begin
            scan_best_in = cur_ff; scan_prio_in = prio_rd_ff;
         end
         cur_in = link_rd_ff; rd_a = link_rd_ff[AW-1:0]; steps_in = steps_ff + IW'(1);
      end
      if (cmd.scan_done) best_in = scan_best_ff;
      if (cmd.rsp_load) begin
         rsp_in.elem = '0; rsp_in.prio = '0; rsp_in.status = lpq_pkg::ST_OK;
         unique case (lpq_pkg::func_type'(req_ff.func))
            lpq_pkg::FUNC_PUSH:
               if (!pushed_ff) rsp_in.status = lpq_pkg::ST_FULL;
            lpq_pkg::FUNC_TOP, lpq_pkg::FUNC_POP:
               if (best_ff == lpq_pkg::NullIdx && !(req_ff.func == lpq_pkg::FUNC_POP
                   && popped_ff)) rsp_in.status = lpq_pkg::ST_EMPTY;
               else begin
                  rsp_in.elem = best_elem_ff; rsp_in.prio = best_prio_ff;
               end
            default: ;
         endcase
         rsp_in.count = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (data_we) begin
         elem_mem[data_wa] <= req_ff.elem;
         prio_mem[data_wa] <= req_ff.prio;
      end
      if (link_we) link_mem[link_wa] <= link_wd;
      elem_rd_ff <= elem_mem[rd_a];
      prio_rd_ff <= prio_mem[rd_a];
      link_rd_ff <= link_mem[rd_a];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= lpq_pkg::NullIdx; tail_ff <= lpq_pkg::NullIdx;
         free_ff <= '0; best_ff <= lpq_pkg::NullIdx; count_ff <= '0;
         init_ff <= '0; cur_ff <= lpq_pkg::NullIdx; scan_best_ff <= lpq_pkg::NullIdx;
         steps_ff <= '0; rsp_ff <= '0; best_fetch_ff <= 1'b0; popped_ff <= 1'b0;
         pushed_ff <= 1'b0;
      end else begin
         head_ff <= head_in; tail_ff <= tail_in; free_ff <= free_in;
         best_ff <= best_in; count_ff <= count_in; init_ff <= init_in;
         cur_ff <= cur_in; scan_best_ff <= scan_best_in; steps_ff <= steps_in;
         rsp_ff <= rsp_in;
         best_fetch_ff <= cmd.read_best;
         if (cmd.capture) popped_ff <= 1'b0;
         if (cmd.free_best) popped_ff <= 1'b1;
         if (cmd.capture) pushed_ff <= 1'b0;
         if (cmd.push_write) pushed_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      scan_prio_ff <= scan_prio_in;
      if (cmd.capture) req_ff <= req;
      if (best_fetch_ff) begin
         best_elem_ff <= elem_rd_ff; best_prio_ff <= prio_rd_ff; best_link_ff <= link_rd_ff;
      end
   end

   assign sts.init_done    = (init_ff == lpq_pkg::NullIdx);
   assign sts.is_empty     = (count_ff == '0) || (best_ff == lpq_pkg::NullIdx);
   assign sts.is_full      = (count_ff >= lpq_pkg::NullIdx) || (free_ff == lpq_pkg::NullIdx);
   assign sts.best_is_head = (best_ff == head_ff);
   assign sts.walk_hit     = cur_valid && (link_rd_ff == best_ff);
   assign sts.walk_end     = !cur_valid || (steps_ff >= lpq_pkg::NullIdx);
   assign sts.scan_end     = !cur_valid || (steps_ff >= lpq_pkg::NullIdx);
   assign rsp = rsp_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= lpq_pkg::NullIdx) else $error("entry count out of range");
   a_empty_null: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 && sts.init_done) |-> head_ff == lpq_pkg::NullIdx)
      else $error("empty queue has a head");
   a_push_grow: assert property (@(posedge clock) disable iff (reset)
      cmd.push_write |=> count_ff == $past(count_ff) + IW'(1))
      else $error("push did not grow count");
endmodule
`default_nettype wire

// ----- hw/rtl/lpq_ctrl.sv -----
`default_nettype none
module lpq_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire logic [1:0]       req_func,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   input  wire lpq_pkg::sts_type sts,
   output      lpq_pkg::cmd_type cmd
);
   typedef enum logic [13:0] {
      S_INIT   = 14'b00000000000001,
      S_IDLE   = 14'b00000000000010,
      S_DECODE = 14'b00000000000100,
      S_PUSH   = 14'b00000000001000,
      S_BWAIT  = 14'b00000000010000,
      S_BGOT   = 14'b00000000100000,
      S_UNLINK = 14'b00000001000000,
      S_WALK   = 14'b00000010000000,
      S_FREE   = 14'b00000100000000,
      S_SCAN   = 14'b00001000000000,
      S_SCANW  = 14'b00010000000000,
      S_LOAD   = 14'b00100000000000,
      S_RSP    = 14'b01000000000000,
      S_LINK   = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] func_ff;
   logic       walk_wait_ff, walk_wait_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      walk_wait_in = 1'b0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_INIT: begin
            cmd.init_step = !sts.init_done;
            if (sts.init_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            // The best node is fetched for every operation: push compares against it.
            cmd.read_best = 1'b1;
            state_in = S_BWAIT;
         end
         S_BWAIT: state_in = S_BGOT;
         S_BGOT: begin
            priority if (func_ff == lpq_pkg::FUNC_PUSH) begin
               state_in = sts.is_full ? S_LOAD : S_LINK;
            end else if (func_ff == lpq_pkg::FUNC_POP && !sts.is_empty) begin
               if (sts.best_is_head) begin
                  state_in = S_UNLINK;
               end else begin
                  cmd.walk_start = 1'b1;
                  walk_wait_in = 1'b1;
                  state_in = S_WALK;
               end
            end else begin
               state_in = S_LOAD;
            end
         end
         S_LINK: begin
            cmd.link_tail = 1'b1;
            state_in = S_PUSH;
         end
         S_PUSH: begin
            cmd.push_write = 1'b1;
            state_in = S_LOAD;
         end
         S_UNLINK: begin
            cmd.unlink_head = 1'b1;
            state_in = S_FREE;
         end
         S_WALK: begin
            // Read data arrives in the cycle after its address.
            if (walk_wait_ff) begin
               walk_wait_in = 1'b0;
            end else if (sts.walk_end) begin
               state_in = S_FREE;
            end else if (sts.walk_hit) begin
               cmd.unlink_mid = 1'b1;
               state_in = S_FREE;
            end else begin
               cmd.walk_step = 1'b1;
               walk_wait_in = 1'b1;
            end
         end
         S_FREE: begin
            cmd.free_best = 1'b1;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_start = 1'b1;
            state_in = S_SCANW;
            walk_wait_in = 1'b1;
         end
         S_SCANW: begin
            if (walk_wait_ff) begin
               walk_wait_in = 1'b0;
            end else if (sts.scan_end) begin
               cmd.scan_done = 1'b1;
               state_in = S_LOAD;
            end else begin
               cmd.scan_step = 1'b1;
               walk_wait_in = 1'b1;
            end
         end
         S_LOAD: begin
            cmd.rsp_load = 1'b1;
            state_in = S_RSP;
         end
         S_RSP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         walk_wait_ff <= 1'b0;
         func_ff <= '0;
      end else begin
         state_ff <= state_in;
         walk_wait_ff <= walk_wait_in;
         if (cmd.capture) func_ff <= req_func;
      end
   end

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_rsp_then_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> state_ff == S_IDLE) else $error("no return to idle");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("request taken while response pending");
endmodule
`default_nettype wire
